>>> rtl/core/plr_pkg.sv
package plr_pkg;

  // Default table geometry
  localparam int TableEntriesDef = 16;
  localparam int CountBitsDef    = 16;

  // Field widths of the ports
  localparam int AddrBits  = 32;
  localparam int LimitBits = 16;
  localparam int PriorBits = 16;

  // request_limit after reset
  localparam logic [LimitBits-1:0] LimitReset = 16'd3;

endpackage

>>> rtl/core/plr_ram.sv
// Generic single-write, single-read RAM with registered read data
module plr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/per_source_request_limiter.sv
// Per-source request limiter. Each input transaction carries one source
// address; the block looks it up in a table of TABLE_ENTRIES entries and
// returns one result transaction: the count of earlier requests from that
// source (0 for a new source), whether the source was found, and a ban flag
// set when that prior count is at least request_limit. Found entries count
// up and saturate; new sources replace entries in round-robin order. A
// request is matched against the address registers and the count memory
// read when it is accepted in IDLE; in UPDATE the updated count is written
// back and the result register loaded. The input is stalled during UPDATE,
// which is held while a previous result is still stalled at the output.
// request_limit is written through cfg_write / cfg_data and
// resets to 3; a limit of 0 bans every request.
module per_source_request_limiter #(
  parameter int TABLE_ENTRIES = plr_pkg::TableEntriesDef,
  parameter int COUNT_BITS    = plr_pkg::CountBitsDef
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [plr_pkg::AddrBits-1:0]  source_address,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          banned,
  output logic [plr_pkg::PriorBits-1:0] prior_count,
  output logic                          table_hit,
  // configuration
  input  logic                          cfg_write,
  input  logic [plr_pkg::LimitBits-1:0] cfg_data
);

  localparam int IDX_BITS = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CMP_BITS = (COUNT_BITS > plr_pkg::LimitBits) ?
                            COUNT_BITS : plr_pkg::LimitBits;
  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(TABLE_ENTRIES - 1);

  typedef enum logic {
    IDLE,
    UPDATE
  } state_t;

  state_t                         state;
  logic [plr_pkg::LimitBits-1:0]  request_limit;
  logic [TABLE_ENTRIES-1:0]       entry_valid;
  logic [plr_pkg::AddrBits-1:0]   entry_address [TABLE_ENTRIES];
  logic [IDX_BITS-1:0]            insert_pointer;

  // lookup stage registers
  logic                           lk_hit;
  logic [IDX_BITS-1:0]            lk_idx;
  logic [plr_pkg::AddrBits-1:0]   lk_addr;

  logic                           in_accept;
  logic                           update_go;
  logic                           match_hit;
  logic [IDX_BITS-1:0]            match_idx;
  logic [COUNT_BITS-1:0]          count_rd;
  logic [COUNT_BITS-1:0]          prior;
  logic [COUNT_BITS-1:0]          count_next;
  logic [CMP_BITS-1:0]            prior_ext;
  logic                           ram_we;
  logic [IDX_BITS-1:0]            ram_waddr;
  logic [COUNT_BITS-1:0]          ram_wdata;

  assign in_stall  = (state != IDLE);
  assign in_accept = in_valid && !in_stall;
  assign update_go = (state == UPDATE) && (!out_valid || !out_stall);

  // parallel address match, lowest valid entry wins
  always_comb begin
    match_hit = 1'b0;
    match_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (entry_valid[i] && (entry_address[i] == source_address)) begin
        match_hit = 1'b1;
        match_idx = IDX_BITS'(i);
      end
    end
  end

  // count memory, read on accept, written in the update cycle
  plr_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (TABLE_ENTRIES)
  ) u_count_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (in_accept),
    .rd_addr (match_idx),
    .rd_data (count_rd)
  );

  // count update, saturating
  always_comb begin
    prior      = lk_hit ? count_rd : '0;
    count_next = (count_rd == '1) ? count_rd : count_rd + COUNT_BITS'(1);
    prior_ext  = CMP_BITS'(prior);
    ram_we     = update_go;
    ram_waddr  = lk_hit ? lk_idx : insert_pointer;
    ram_wdata  = lk_hit ? count_next : COUNT_BITS'(1);
  end

  // lookup stage payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      lk_hit  <= match_hit;
      lk_idx  <= match_idx;
      lk_addr <= source_address;
    end
  end

  // address store, replaced on a miss
  always_ff @(posedge clk) begin
    if (update_go && !lk_hit) begin
      entry_address[insert_pointer] <= lk_addr;
    end
  end

  // control, table marks and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      request_limit  <= plr_pkg::LimitReset;
      entry_valid    <= '0;
      insert_pointer <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        request_limit <= cfg_data;
      end
      if (out_valid && !out_stall && !update_go) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_accept) begin
            state <= UPDATE;
          end
        end
        UPDATE: begin
          if (update_go) begin
            state       <= IDLE;
            out_valid   <= 1'b1;
            table_hit   <= lk_hit;
            banned      <= (prior_ext >= CMP_BITS'(request_limit));
            prior_count <= (prior_ext > CMP_BITS'({plr_pkg::PriorBits{1'b1}})) ?
                           {plr_pkg::PriorBits{1'b1}} :
                           plr_pkg::PriorBits'(prior_ext);
            if (!lk_hit) begin
              entry_valid[insert_pointer] <= 1'b1;
              insert_pointer <= (insert_pointer == LAST_IDX) ?
                                '0 : insert_pointer + IDX_BITS'(1);
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
